@@ rtl/core/mmpt_pkg.sv @@
// ----------------------------------------------------------------------------
// mmpt_pkg
// Shared types and constants for the memory map pointer translator: table
// geometry, command and status codes, sequencer states and the entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package mmpt_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int PAGE_SHIFT  = 12;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // field widths
  localparam int ADDR_W  = 64;
  localparam int PAGES_W = 52;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  // stream payload widths, padded to whole bytes
  localparam int IN_BITS    = 3 * ADDR_W + PAGES_W + 3;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = STAT_W + ADDR_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // window past the end of an entry used by the fallback match
  localparam logic [ADDR_W-1:0] GP_WINDOW = ADDR_W'(64'h20_0000);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_CONVERT = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_SUCCESS    = 2'd0,
    ST_INVALID    = 2'd1,
    ST_NOT_FOUND  = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WALK = 2'd1,
    S_DONE = 2'd2
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]  phys_start;
    logic [PAGES_W-1:0] page_count;
    logic [ADDR_W-1:0]  virt_start;
    logic               runtime;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/core/memory_map_pointer_translator_core.sv @@
// ----------------------------------------------------------------------------
// memory_map_pointer_translator_core
// Table of memory-map descriptors with clear, append and address convert.
// ----------------------------------------------------------------------------
// The descriptor table sits in one single-port-write, registered-read memory
// of TABLE_DEPTH entries. Clear and append skip the walk. A convert of a
// nonzero address walks the stored entries one per cycle through a three
// stage read / range / match pipeline and stops early when an entry's page
// range holds the address. A null address or the unused command code also
// skips the walk. A finished result sits in the output register while the
// next item is taken. The table is written only when an item is accepted and
// read only during a walk, so the two never overlap. There is no clearing
// pass: the entry count bounds every read.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_map_pointer_translator_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // slave side
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // phys_start, page_count, virt_start, runtime, address, optional_ok,
  // gp_pointer (from bit 0 up), zero padded
  input  wire logic [mmpt_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // command
  input  wire logic [mmpt_pkg::CMD_W-1:0]     s_axis_tuser,
  // master side
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // status, converted_address (from bit 0 up), zero padded
  output logic [mmpt_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  import mmpt_pkg::*;

  // input unpacking
  entry_t            in_entry;
  logic [ADDR_W-1:0] in_addr;
  logic              in_opt_ok;
  logic              in_gp;
  cmd_e              in_cmd;

  assign in_entry.phys_start = s_axis_tdata[ADDR_W-1:0];
  assign in_entry.page_count = s_axis_tdata[ADDR_W +: PAGES_W];
  assign in_entry.virt_start = s_axis_tdata[ADDR_W+PAGES_W +: ADDR_W];
  assign in_entry.runtime    = s_axis_tdata[2*ADDR_W+PAGES_W];
  assign in_addr             = s_axis_tdata[2*ADDR_W+PAGES_W+1 +: ADDR_W];
  assign in_opt_ok           = s_axis_tdata[3*ADDR_W+PAGES_W+1];
  assign in_gp               = s_axis_tdata[3*ADDR_W+PAGES_W+2];
  assign in_cmd              = cmd_e'(s_axis_tuser);

  // state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic              gp_q, gp_d;
  status_e           res_status_q, res_status_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic              win_valid_q, win_valid_d;
  logic [ADDR_W-1:0] win_addr_q, win_addr_d;

  // walk pipeline
  logic              v1_q, v1_d;
  logic              v2_q, v2_d;
  entry_t            rd_data_q;
  logic [ADDR_W-1:0] end_q, diff_q, virt_q;
  logic              ge_q;

  // output register
  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q;

  // control
  logic accept;
  logic issue;
  logic load_out;
  logic walk_end;
  logic hit_now;
  logic win_now;
  logic wr_en;

  // table memory
  entry_t mem [TABLE_DEPTH];

  // stage 3 match logic
  logic [ADDR_W-1:0] end_win;
  logic [ADDR_W-1:0] trans;

  assign end_win = end_q + GP_WINDOW;
  assign trans   = diff_q + virt_q;
  assign hit_now = v2_q && ge_q && (addr_q < end_q);
  assign win_now = v2_q && ge_q && !(addr_q < end_q) && (addr_q < end_win);

  assign walk_end = (idx_q >= cnt_q) && !v1_q && !v2_q;

  // sequencer outputs
  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    load_out      = 1'b0;
    unique case (state_q)
      S_IDLE: s_axis_tready = 1'b1;
      S_WALK: issue = (idx_q < cnt_q) && !hit_now;
      S_DONE: load_out = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign accept = s_axis_tvalid && s_axis_tready;
  assign wr_en  = accept && (in_cmd == CMD_APPEND) && (cnt_q < CNT_W'(TABLE_DEPTH));

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_CONVERT && in_addr != '0) begin
            state_d = S_WALK;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_WALK: begin
        if (hit_now || walk_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath next values
  always_comb begin
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    addr_d       = addr_q;
    gp_d         = gp_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    win_valid_d  = win_valid_q;
    win_addr_d   = win_addr_q;
    v1_d         = issue;
    v2_d         = v1_q && (state_q == S_WALK) && !hit_now;

    // command decode at accept
    if (accept) begin
      res_status_d = ST_SUCCESS;
      res_addr_d   = '0;
      addr_d       = in_addr;
      gp_d         = in_gp;
      idx_d        = '0;
      win_valid_d  = 1'b0;
      unique case (in_cmd)
        CMD_CLEAR: cnt_d = '0;
        CMD_APPEND: begin
          if (wr_en) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            res_status_d = ST_TABLE_FULL;
          end
        end
        CMD_CONVERT: begin
          if (in_addr == '0) begin
            res_status_d = in_opt_ok ? ST_SUCCESS : ST_INVALID;
          end
        end
        default: begin
          res_status_d = ST_INVALID;
          res_addr_d   = in_addr;
        end
      endcase
    end

    // table walk
    if (state_q == S_WALK) begin
      if (issue) begin
        idx_d = idx_q + CNT_W'(1);
      end
      if (win_now) begin
        win_valid_d = 1'b1;
        win_addr_d  = trans;
      end
      priority if (hit_now) begin
        res_status_d = ST_SUCCESS;
        res_addr_d   = trans;
      end else if (walk_end) begin
        if (gp_q && win_valid_q) begin
          res_status_d = ST_SUCCESS;
          res_addr_d   = win_addr_q;
        end else begin
          res_status_d = ST_NOT_FOUND;
          res_addr_d   = addr_q;
        end
      end
    end
  end

  // output handshake
  always_comb begin
    m_valid_d = m_valid_q;
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      v1_q      <= v1_d;
      v2_q      <= v2_d;
      m_valid_q <= m_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    addr_q       <= addr_d;
    gp_q         <= gp_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    win_valid_q  <= win_valid_d;
    win_addr_q   <= win_addr_d;
    if (load_out) begin
      m_data_q <= OUT_DATA_W'({res_addr_q, res_status_q});
    end
  end

  // table memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[IDX_W-1:0]] <= in_entry;
    end
    if (issue) begin
      rd_data_q <= mem[idx_q[IDX_W-1:0]];
    end
  end

  // stage 2: range end, offset and lower bound
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      end_q  <= rd_data_q.phys_start + (ADDR_W'(rd_data_q.page_count) << PAGE_SHIFT);
      diff_q <= addr_q - rd_data_q.phys_start;
      ge_q   <= rd_data_q.runtime && (addr_q >= rd_data_q.phys_start);
      virt_q <= rd_data_q.virt_start;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

@@ rtl/core/mmpt_checker.sv @@
// ----------------------------------------------------------------------------
// mmpt_checker
// Port-level checks for the memory map pointer translator, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module mmpt_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready,
  input wire logic [mmpt_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  import mmpt_pkg::*;

  logic [STAT_W-1:0] out_status;
  logic [ADDR_W-1:0] out_addr;
  logic              in_acc;

  assign out_status = m_axis_tdata[STAT_W-1:0];
  assign out_addr   = m_axis_tdata[STAT_W +: ADDR_W];
  assign in_acc     = s_axis_tvalid && s_axis_tready;

  // one item in flight: intake closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready)
    else $error("intake stayed open after an item was accepted");

  // a new result only appears while intake is closed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while intake was open");

  // a full table reports a zero address
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_status == ST_TABLE_FULL) |-> (out_addr == '0))
    else $error("table full result carries a nonzero address");

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind memory_map_pointer_translator_core mmpt_checker u_mmpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

@@ test/tb_memory_map_pointer_translator_core.sv @@
// ----------------------------------------------------------------------------
// tb_memory_map_pointer_translator_core
// Self-checking bench for the descriptor table: clear, append and convert
// items go in on the slave stream and a scoreboard with its own copy of the
// table predicts every status and converted address seen on the master side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_memory_map_pointer_translator_core;
  import mmpt_pkg::*;

  // command code with no operation behind it
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

  localparam int unsigned ITEM_TARGET  = 1050;
  localparam int unsigned QUIET_TAIL   = 100;
  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned REPORT_CAP   = 100;

  // slave item fields, phys_start in the lowest bits
  typedef struct packed {
    logic               gp_pointer;
    logic               optional_ok;
    logic [ADDR_W-1:0]  address;
    logic               runtime;
    logic [ADDR_W-1:0]  virt_start;
    logic [PAGES_W-1:0] page_count;
    logic [ADDR_W-1:0]  phys_start;
  } xlat_req_t;

  // master item fields, status in the lowest bits
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    status_e           status;
  } xlat_rsp_t;

  // scoreboard: shadow table plus the queue of predicted results
  class xlat_scoreboard;
    logic [ADDR_W-1:0]  phys_tab  [TABLE_DEPTH];
    logic [PAGES_W-1:0] pages_tab [TABLE_DEPTH];
    logic [ADDR_W-1:0]  virt_tab  [TABLE_DEPTH];
    logic               rt_tab    [TABLE_DEPTH];
    int unsigned        n_entries;
    xlat_rsp_t          expected_rsp [$];
    int unsigned        mismatches;

    function new();
      n_entries   = 0;
      mismatches  = 0;
    endfunction

    // next result for one command, updating the shadow table
    function xlat_rsp_t predict_translation(logic [CMD_W-1:0] cmd, xlat_req_t req);
      xlat_rsp_t         rsp;
      logic [ADDR_W-1:0] range_end;
      logic [ADDR_W-1:0] win_end;
      logic [ADDR_W-1:0] win_addr;
      logic              win_valid;
      logic              hit;
      rsp.status  = ST_SUCCESS;
      rsp.address = '0;
      win_addr    = '0;
      win_valid   = 1'b0;
      hit         = 1'b0;
      if (cmd == CMD_CLEAR) begin
        n_entries = 0;
      end else if (cmd == CMD_APPEND) begin
        if (n_entries >= TABLE_DEPTH) begin
          rsp.status = ST_TABLE_FULL;
        end else begin
          phys_tab[n_entries]  = req.phys_start;
          pages_tab[n_entries] = req.page_count;
          virt_tab[n_entries]  = req.virt_start;
          rt_tab[n_entries]    = req.runtime;
          n_entries++;
        end
      end else if (cmd == CMD_CONVERT) begin
        if (req.address == '0) begin
          rsp.status = req.optional_ok ? ST_SUCCESS : ST_INVALID;
        end else begin
          // first page-range hit wins, last past-end window is the fallback
          for (int i = 0; i < n_entries && !hit; i++) begin
            if (rt_tab[i] && req.address >= phys_tab[i]) begin
              range_end = phys_tab[i] + (ADDR_W'(pages_tab[i]) << PAGE_SHIFT);
              win_end   = range_end + GP_WINDOW;
              if (req.address < range_end) begin
                rsp.address = req.address - phys_tab[i] + virt_tab[i];
                hit         = 1'b1;
              end else if (req.address < win_end) begin
                win_addr  = req.address - phys_tab[i] + virt_tab[i];
                win_valid = 1'b1;
              end
            end
          end
          if (hit) begin
            rsp.status = ST_SUCCESS;
          end else if (req.gp_pointer && win_valid) begin
            rsp.status  = ST_SUCCESS;
            rsp.address = win_addr;
          end else begin
            rsp.status  = ST_NOT_FOUND;
            rsp.address = req.address;
          end
        end
      end else begin
        rsp.status  = ST_INVALID;
        rsp.address = req.address;
      end
      return rsp;
    endfunction

    function void note_request(logic [CMD_W-1:0] cmd, xlat_req_t req);
      expected_rsp.push_back(predict_translation(cmd, req));
    endfunction

    function void check_response(logic [OUT_DATA_W-1:0] tdata);
      xlat_rsp_t got;
      xlat_rsp_t want;
      got = tdata[OUT_BITS-1:0];
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: unexpected item, expected none, actual status %0d address %h",
                   $time, got.status, got.address);
        return;
      end
      want = expected_rsp.pop_front();
      if (got.status !== want.status) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, got.status);
      end
      if (got.address !== want.address) begin
        mismatches++;
        if (mismatches <= REPORT_CAP)
          $display("%0t: converted address mismatch, expected %h, actual %h",
                   $time, want.address, got.address);
      end
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]      s_axis_tuser  = CMD_CLEAR;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  xlat_scoreboard xlat_sb;
  int unsigned    items_sent   = 0;
  bit             tx_gaps_on   = 1'b1;
  bit             rx_stalls_on = 1'b1;
  bit             hold_req     = 1'b0;
  longint         cycle_count  = 0;

  memory_map_pointer_translator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver: random stall bursts and one long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      xlat_sb.check_response(m_axis_tdata);
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic xlat_req_t noise_req();
    xlat_req_t req;
    req.phys_start  = rand64();
    req.page_count  = PAGES_W'(rand64());
    req.virt_start  = rand64();
    req.runtime     = 1'($urandom_range(0, 1));
    req.address     = rand64();
    req.optional_ok = 1'($urandom_range(0, 1));
    req.gp_pointer  = 1'($urandom_range(0, 1));
    return req;
  endfunction

  function automatic xlat_req_t desc_req(logic [ADDR_W-1:0] phys, logic [PAGES_W-1:0] pages,
                                         logic [ADDR_W-1:0] virt, logic rt);
    xlat_req_t req;
    req            = '0;
    req.phys_start = phys;
    req.page_count = pages;
    req.virt_start = virt;
    req.runtime    = rt;
    return req;
  endfunction

  function automatic xlat_req_t conv_req(logic [ADDR_W-1:0] addr, logic opt, logic gp);
    xlat_req_t req;
    req             = '0;
    req.address     = addr;
    req.optional_ok = opt;
    req.gp_pointer  = gp;
    return req;
  endfunction

  // descriptor clustered around a base so ranges and windows overlap
  function automatic xlat_req_t random_desc(logic [ADDR_W-1:0] base);
    xlat_req_t req;
    req = noise_req();
    if ($urandom_range(0, 9) != 0)
      req.phys_start = base + (ADDR_W'($urandom_range(0, 255)) << 14);
    case ($urandom_range(0, 15))
      0:       req.page_count = PAGES_W'(rand64());
      1:       req.page_count = '1;
      default: req.page_count = PAGES_W'($urandom_range(0, 64));
    endcase
    req.runtime = ($urandom_range(0, 3) != 0);
    return req;
  endfunction

  // address, mostly aimed at an edge of a stored entry
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned       idx;
    logic [ADDR_W-1:0] phys;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] range_end;
    if ($urandom_range(0, 19) == 0)
      return '0;
    if (xlat_sb.n_entries == 0 || $urandom_range(0, 9) == 0)
      return rand64();
    idx       = $urandom_range(0, xlat_sb.n_entries - 1);
    phys      = xlat_sb.phys_tab[idx];
    span      = ADDR_W'(xlat_sb.pages_tab[idx]) << PAGE_SHIFT;
    range_end = phys + span;
    case ($urandom_range(0, 7))
      0: return phys;
      1: return (span == '0) ? phys : phys + (rand64() % span);
      2: return range_end - 1;
      3: return range_end;
      4: return range_end + ADDR_W'($urandom_range(0, 32'h1F_FFFF));
      5: return range_end + GP_WINDOW - 1;
      6: return range_end + GP_WINDOW;
      default: return phys - 1;
    endcase
  endfunction

  task automatic send_item(logic [CMD_W-1:0] cmd, xlat_req_t req);
    int unsigned gap;
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(req);
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    xlat_sb.note_request(cmd, req);
    items_sent++;
  endtask

  // sender pause until every result is back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (xlat_sb.expected_rsp.size() != 0) @(posedge clk_i);
  endtask

  // optionally clear, fill with clustered descriptors, then convert near them
  task automatic run_table_sequence(bit fill_up);
    logic [ADDR_W-1:0] base;
    int unsigned       n_desc;
    int unsigned       n_conv;
    case ($urandom_range(0, 3))
      0:       base = rand64();
      1:       base = 64'hFFFF_FFFF_FFC0_0000 + ADDR_W'($urandom_range(0, 32'h3F_FFFF));
      2:       base = ADDR_W'($urandom_range(0, 32'h3F_FFFF));
      default: base = rand64() & ~ADDR_W'(32'hFFF);
    endcase
    if (fill_up || $urandom_range(0, 5) != 0)
      send_item(CMD_CLEAR, noise_req());
    if (fill_up)
      n_desc = $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 4);
    else if ($urandom_range(0, 5) == 0)
      n_desc = $urandom_range(20, TABLE_DEPTH + 4);
    else
      n_desc = $urandom_range(1, 8);
    repeat (n_desc) send_item(CMD_APPEND, random_desc(base));
    n_conv = $urandom_range(4, 12);
    repeat (n_conv) begin
      xlat_req_t req;
      req         = noise_req();
      req.address = pick_address();
      send_item(CMD_CONVERT, req);
    end
  endtask

  // stimulus
  initial begin
    bit          hold_done;
    bit          drain_done;
    int unsigned seq_no;
    xlat_sb    = new();
    hold_done  = 1'b0;
    drain_done = 1'b0;
    seq_no     = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table, null address, reserved command
    send_item(CMD_CONVERT, conv_req('1, 1'b0, 1'b1));
    send_item(CMD_CONVERT, conv_req('0, 1'b0, 1'b0));
    send_item(CMD_CONVERT, conv_req('0, 1'b1, 1'b1));
    send_item(CMD_CONVERT, conv_req(64'h0000_0000_1000_0000, 1'b1, 1'b1));
    send_item(CMD_RESERVED, conv_req(64'hDEAD_BEEF_0123_4567, 1'b1, 1'b1));

    // field extremes, a non-runtime entry, an empty range at zero
    send_item(CMD_APPEND, desc_req(64'h1000_0000, 52'd4, 64'hFFFF_FFFF_FFFF_0000, 1'b1));
    send_item(CMD_APPEND, desc_req(64'h2000_0000, 52'd16, 64'h0000_0000_8000_0000, 1'b0));
    send_item(CMD_APPEND, desc_req('1, '1, '1, 1'b1));
    send_item(CMD_APPEND, desc_req('0, '0, '0, 1'b1));
    // window match that translates to zero
    send_item(CMD_APPEND, desc_req(64'h4000_0000, 52'd1, 64'hFFFF_FFFF_FFFF_EFF0, 1'b1));

    // range edges, window edges, gp on and off
    send_item(CMD_CONVERT, conv_req(64'h1000_0000, 1'b0, 1'b0));
    send_item(CMD_CONVERT, conv_req(64'h1000_3FFF, 1'b0, 1'b0));
    send_item(CMD_CONVERT, conv_req(64'h1000_4000, 1'b0, 1'b0));
    send_item(CMD_CONVERT, conv_req(64'h1000_4000, 1'b0, 1'b1));
    send_item(CMD_CONVERT, conv_req(64'h1020_3FFF, 1'b0, 1'b1));
    send_item(CMD_CONVERT, conv_req(64'h1020_4000, 1'b0, 1'b1));
    send_item(CMD_CONVERT, conv_req(64'h2000_0010, 1'b0, 1'b1));
    send_item(CMD_CONVERT, conv_req(64'h4000_1010, 1'b0, 1'b1));
    send_item(CMD_CONVERT, conv_req('1, 1'b1, 1'b1));
    send_item(CMD_CONVERT, conv_req(64'h10, 1'b0, 1'b1));

    // clear, then the table starts over
    send_item(CMD_CLEAR, conv_req('0, 1'b0, 1'b0));
    send_item(CMD_CONVERT, conv_req(64'h1000_0000, 1'b0, 1'b1));
    send_item(CMD_APPEND, desc_req(64'h8000_0000, 52'd2, 64'h0, 1'b1));
    send_item(CMD_CONVERT, conv_req(64'h8000_1234, 1'b0, 1'b0));

    // random part: mostly table sequences, some noise items
    while (items_sent < ITEM_TARGET) begin
      if (items_sent + QUIET_TAIL >= ITEM_TARGET) begin
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
      end else begin
        tx_gaps_on   = ($urandom_range(0, 3) != 0);
        rx_stalls_on = ($urandom_range(0, 3) != 0);
      end
      if (!hold_done && items_sent >= 350) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && items_sent >= 650) begin
        drain_results();
        drain_done = 1'b1;
      end
      if (seq_no != 0 && $urandom_range(0, 7) == 0)
        send_item(CMD_W'($urandom_range(0, 3)), noise_req());
      else
        run_table_sequence(seq_no == 0 || $urandom_range(0, 15) == 0);
      seq_no++;
    end

    // wind down and report
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (xlat_sb.expected_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (xlat_sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
